@@ sv/c2dv_pkg.sv @@
package c2dv_pkg;

  // parameter defaults
  localparam int MAX_MAP_COLS_DEF = 64;
  localparam int MAX_KERNEL_DEF   = 5;

  // field and register widths
  localparam int DATA_W     = 16;
  localparam int DIM_W      = 11;
  localparam int MC_REG_W   = 7;
  localparam int K_REG_W    = 3;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 6;
  localparam int CIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = 4;
  localparam int FRAC_SHIFT = 12;
  localparam int MAX_MAP_ROWS = 1024;

  // register reset values
  localparam logic [DIM_W-1:0]    MAP_ROWS_RST    = DIM_W'(28);
  localparam logic [MC_REG_W-1:0] MAP_COLS_RST    = MC_REG_W'(28);
  localparam logic [K_REG_W-1:0]  KERNEL_ROWS_RST = K_REG_W'(5);
  localparam logic [K_REG_W-1:0]  KERNEL_COLS_RST = K_REG_W'(5);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_ROWS,
    CFG_MAP_COLS,
    CFG_KERNEL_ROWS,
    CFG_KERNEL_COLS
  } cfg_reg_t;

  // input commands
  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic                     smp;
    logic                     coef;
    logic                     emit;
    logic                     last;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [SLOT_W-1:0]        slot;
    logic [SLOT_W-1:0]        base;
    logic [CIDX_W-1:0]        cidx;
    logic signed [DATA_W-1:0] value;
  } item_t;

endpackage

@@ sv/c2dv_if.sv @@
interface c2dv_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [c2dv_pkg::DATA_W-1:0] value;
  logic [c2dv_pkg::CIDX_W-1:0]        coef_index;

  modport source (output valid, output cmd, output value, output coef_index, input ready);
  modport sink (input valid, input cmd, input value, input coef_index, output ready);
endinterface

interface c2dv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [c2dv_pkg::DATA_W-1:0] out_value;
  logic [c2dv_pkg::ROW_W-1:0]         out_row;
  logic [c2dv_pkg::COL_W-1:0]         out_col;
  logic                               last;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input out_value, input out_row, input out_col,
                input last, output ready);
endinterface

@@ sv/conv2d_valid_sliding_window.sv @@
// after its sample transfer a result passes the read, window, product and row-sum registers into the output register
// throughput: one item per cycle; the whole pipeline holds while a result waits untaken
// the column memory gives one read and one write per cycle, bypassed on same-column reuse
// reset: synchronous, active low; counters at zero, registers at their defaults
// after reset a clearing pass zeroes every column word of the line memory, input not ready
// coefficient registers are undefined until written
module conv2d_valid_sliding_window #(
  parameter int MAX_MAP_COLS = c2dv_pkg::MAX_MAP_COLS_DEF,
  parameter int MAX_KERNEL   = c2dv_pkg::MAX_KERNEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  c2dv_in_if.sink                        in_ch,
  c2dv_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [c2dv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c2dv_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MAX_MAP_COLS);
  localparam int KW = $clog2(MAX_KERNEL + 1);

  logic            en, acc, clr_busy, s2_valid, out_valid;
  c2dv_pkg::item_t item, s2_item;
  logic [AW-1:0]   col_addr;
  logic [KW-1:0]   kr, kc;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][c2dv_pkg::DATA_W-1:0] win;

  // pipeline advances unless a result waits untaken
  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en && !clr_busy;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  c2dv_ctrl #(
    .MAX_MAP_COLS (MAX_MAP_COLS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .cmd        (in_ch.cmd),
    .value      (in_ch.value),
    .coef_index (in_ch.coef_index),
    .item       (item),
    .col_addr   (col_addr),
    .kr         (kr),
    .kc         (kc)
  );

  c2dv_linebuf #(
    .MAX_MAP_COLS (MAX_MAP_COLS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .item_in  (item),
    .addr_in  (col_addr),
    .clr_busy (clr_busy),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .win      (win)
  );

  c2dv_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s2_valid  (s2_valid),
    .s2_item   (s2_item),
    .win       (win),
    .kr        (kr),
    .kc        (kc),
    .out_valid (out_valid),
    .out_value (out_ch.out_value),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last)
  );

endmodule

@@ sv/c2dv_ctrl.sv @@
module c2dv_ctrl #(
  parameter int MAX_MAP_COLS = c2dv_pkg::MAX_MAP_COLS_DEF,
  parameter int MAX_KERNEL   = c2dv_pkg::MAX_KERNEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [c2dv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c2dv_pkg::DIM_W-1:0]          cfg_wdata,
  input  logic                                acc,
  input  logic                                cmd,
  input  logic signed [c2dv_pkg::DATA_W-1:0]  value,
  input  logic [c2dv_pkg::CIDX_W-1:0]         coef_index,
  output c2dv_pkg::item_t                     item,
  output logic [$clog2(MAX_MAP_COLS)-1:0]     col_addr,
  output logic [$clog2(MAX_KERNEL+1)-1:0]     kr,
  output logic [$clog2(MAX_KERNEL+1)-1:0]     kc
);

  localparam int AW = $clog2(MAX_MAP_COLS);
  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int DW = c2dv_pkg::DIM_W;
  localparam int BW = c2dv_pkg::SLOT_W + 1;

  logic [DW-1:0]                   map_rows_r;
  logic [c2dv_pkg::MC_REG_W-1:0]   map_cols_r;
  logic [c2dv_pkg::K_REG_W-1:0]    kernel_rows_r;
  logic [c2dv_pkg::K_REG_W-1:0]    kernel_cols_r;
  logic [c2dv_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [AW-1:0]                   col_r, col_nxt;
  logic [c2dv_pkg::SLOT_W-1:0]     slot_r, slot_nxt;

  logic [DW-1:0] mr, mc, r_ext, c_ext, r1, c1, row0, col0;
  logic          in_range, c_last, r_last, smp_acc;
  logic [BW-1:0] base_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_rows_r    <= c2dv_pkg::MAP_ROWS_RST;
      map_cols_r    <= c2dv_pkg::MAP_COLS_RST;
      kernel_rows_r <= c2dv_pkg::KERNEL_ROWS_RST;
      kernel_cols_r <= c2dv_pkg::KERNEL_COLS_RST;
    end else if (cfg_we) begin
      unique case (c2dv_pkg::cfg_reg_t'(cfg_index))
        c2dv_pkg::CFG_MAP_ROWS:    map_rows_r    <= cfg_wdata;
        c2dv_pkg::CFG_MAP_COLS:    map_cols_r    <= cfg_wdata[c2dv_pkg::MC_REG_W-1:0];
        c2dv_pkg::CFG_KERNEL_ROWS: kernel_rows_r <= cfg_wdata[c2dv_pkg::K_REG_W-1:0];
        c2dv_pkg::CFG_KERNEL_COLS: kernel_cols_r <= cfg_wdata[c2dv_pkg::K_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    mr = (map_rows_r == '0) ? DW'(1) :
         (map_rows_r > DW'(c2dv_pkg::MAX_MAP_ROWS)) ? DW'(c2dv_pkg::MAX_MAP_ROWS) : map_rows_r;
    mc = (map_cols_r == '0) ? DW'(1) :
         (int'(map_cols_r) > MAX_MAP_COLS) ? DW'(MAX_MAP_COLS) : DW'(map_cols_r);
    kr = (kernel_rows_r == '0) ? KW'(1) :
         (int'(kernel_rows_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_rows_r);
    kc = (kernel_cols_r == '0) ? KW'(1) :
         (int'(kernel_cols_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_cols_r);
  end

  // position decode and next counters
  always_comb begin
    smp_acc  = acc && (cmd == c2dv_pkg::CMD_SAMPLE);
    r_ext    = DW'(row_r);
    c_ext    = DW'(col_r);
    r1       = r_ext + DW'(1);
    c1       = c_ext + DW'(1);
    in_range = (r_ext < mr) && (c_ext < mc);
    c_last   = (c1 >= mc);
    r_last   = (r1 >= mr);
    row0     = r1 - DW'(kr);
    col0     = c1 - DW'(kc);
    base_sum = BW'(slot_r) + BW'(MAX_KERNEL + 1) - BW'(kr);

    col_nxt  = c_last ? '0 : AW'(c1);
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (c_last) begin
      if (r_last) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = c2dv_pkg::ROW_W'(r1);
        slot_nxt = (slot_r == c2dv_pkg::SLOT_W'(MAX_KERNEL - 1)) ? '0 :
                   slot_r + c2dv_pkg::SLOT_W'(1);
      end
    end
  end

  // item handed to the line buffer
  always_comb begin
    item.smp   = smp_acc;
    item.coef  = acc && (cmd == c2dv_pkg::CMD_COEF);
    item.emit  = in_range && (r1 >= DW'(kr)) && (c1 >= DW'(kc));
    item.last  = c_last && r_last;
    item.row   = row0[c2dv_pkg::ROW_W-1:0];
    item.col   = col0[c2dv_pkg::COL_W-1:0];
    item.slot  = slot_r;
    item.base  = (int'(base_sum) >= MAX_KERNEL) ? c2dv_pkg::SLOT_W'(base_sum - BW'(MAX_KERNEL))
                                                : c2dv_pkg::SLOT_W'(base_sum);
    item.cidx  = coef_index;
    item.value = value;
    col_addr   = col_r;
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (smp_acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // line slot follows the row count modulo MAX_KERNEL
  a_slot_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == '0) |-> (slot_r == '0))
    else $error("line slot out of step with row counter");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc |=> (int'(slot_r) < MAX_KERNEL))
    else $error("line slot beyond kernel height");

endmodule

@@ sv/c2dv_linebuf.sv @@
module c2dv_linebuf #(
  parameter int MAX_MAP_COLS = c2dv_pkg::MAX_MAP_COLS_DEF,
  parameter int MAX_KERNEL   = c2dv_pkg::MAX_KERNEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  c2dv_pkg::item_t                     item_in,
  input  logic [$clog2(MAX_MAP_COLS)-1:0]     addr_in,
  output logic                                clr_busy,
  output logic                                s2_valid,
  output c2dv_pkg::item_t                     s2_item,
  output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][c2dv_pkg::DATA_W-1:0] win
);

  localparam int AW = $clog2(MAX_MAP_COLS);
  localparam int DW = c2dv_pkg::DATA_W;
  localparam int LW = MAX_KERNEL * DW;

  // one word per column holds that column of every stored line
  logic [LW-1:0] mem [MAX_MAP_COLS];
  logic [LW-1:0] rd_data_r;

  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;
  logic            s1_valid_r, s2_valid_r;
  c2dv_pkg::item_t s1_item_r, s2_item_r;
  logic [AW-1:0]   s1_addr_r;
  logic            fwd_hit_r;
  logic [LW-1:0]   fwd_word_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [LW-1:0]   wr_data, merged, old_word;

  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][DW-1:0] win_r;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_MAP_COLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // merge the new sample into its line slot
  always_comb begin
    old_word = fwd_hit_r ? fwd_word_r : rd_data_r;
    merged   = old_word;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      if (s1_item_r.slot == c2dv_pkg::SLOT_W'(i)) begin
        merged[i*DW +: DW] = s1_item_r.value;
      end
    end
    wr_en   = clr_busy_r || (en && s1_valid_r && s1_item_r.smp);
    wr_addr = clr_busy_r ? clr_addr_r : s1_addr_r;
    wr_data = clr_busy_r ? '0 : merged;
  end

  // column memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.smp) begin
      rd_data_r <= mem[addr_in];
    end
  end

  // read stage, with bypass of a write to the same column at the read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r <= item_in.smp || item_in.coef;
      fwd_hit_r  <= item_in.smp && wr_en && (wr_addr == addr_in);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r  <= item_in;
      s1_addr_r  <= addr_in;
      fwd_word_r <= wr_data;
    end
  end

  // window of the newest columns, index 0 is the current column
  always_ff @(posedge clk) begin
    if (en && s1_valid_r && s1_item_r.smp) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        win_r[i] <= {win_r[i][MAX_KERNEL-2:0], merged[i*DW +: DW]};
      end
    end
  end

  // hand-over to the multiplier stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item_r <= s1_item_r;
    end
  end

  assign clr_busy = clr_busy_r;
  assign s2_valid = s2_valid_r;
  assign s2_item  = s2_item_r;
  assign win      = win_r;

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !s2_valid_r))
    else $error("item in flight during clearing pass");

  a_clr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_busy_r && (clr_addr_r == AW'(MAX_MAP_COLS - 1))) |=> !clr_busy_r)
    else $error("clearing pass did not finish at last column");

endmodule

@@ sv/c2dv_mac.sv @@
module c2dv_mac #(
  parameter int MAX_KERNEL = c2dv_pkg::MAX_KERNEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                s2_valid,
  input  c2dv_pkg::item_t                     s2_item,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][c2dv_pkg::DATA_W-1:0] win,
  input  logic [$clog2(MAX_KERNEL+1)-1:0]     kr,
  input  logic [$clog2(MAX_KERNEL+1)-1:0]     kc,
  output logic                                out_valid,
  output logic signed [c2dv_pkg::DATA_W-1:0]  out_value,
  output logic [c2dv_pkg::ROW_W-1:0]          out_row,
  output logic [c2dv_pkg::COL_W-1:0]          out_col,
  output logic                                out_last
);

  localparam int DW   = c2dv_pkg::DATA_W;
  localparam int KW   = $clog2(MAX_KERNEL + 1);
  localparam int JW   = $clog2(MAX_KERNEL);
  localparam int NK   = MAX_KERNEL * MAX_KERNEL;
  localparam int KIW  = $clog2(NK);
  localparam int PW   = 2 * DW;
  localparam int RW   = PW + $clog2(MAX_KERNEL);
  localparam int ACW  = PW + $clog2(NK);
  localparam int SW   = c2dv_pkg::SLOT_W + 1;
  localparam logic signed [ACW-1:0] SAT_HI = ACW'(2**(DW-1) - 1);
  localparam logic signed [ACW-1:0] SAT_LO = ~SAT_HI;

  logic signed [DW-1:0] kern_r [NK];

  logic signed [PW-1:0] prod_nxt [MAX_KERNEL][MAX_KERNEL];
  logic signed [PW-1:0] prod_r   [MAX_KERNEL][MAX_KERNEL];
  logic signed [RW-1:0] rsum_nxt [MAX_KERNEL];
  logic signed [RW-1:0] rsum_r   [MAX_KERNEL];
  logic signed [ACW-1:0] total, shifted;
  logic signed [DW-1:0]  sat_value;

  logic            s3_valid_r, s4_valid_r, out_valid_r;
  c2dv_pkg::item_t s3_item_r, s4_item_r;
  logic signed [DW-1:0]         out_value_r;
  logic [c2dv_pkg::ROW_W-1:0]   out_row_r;
  logic [c2dv_pkg::COL_W-1:0]   out_col_r;
  logic                         out_last_r;

  // coefficient registers, written in item order behind earlier windows
  always_ff @(posedge clk) begin
    if (en && s2_valid && s2_item.coef && (int'(s2_item.cidx) < NK)) begin
      kern_r[KIW'(s2_item.cidx)] <= s2_item.value;
    end
  end

  // tap selection and products
  always_comb begin
    logic [SW-1:0]        sl_sum;
    logic [JW-1:0]        sl_idx, col_idx;
    logic [KW-1:0]        jj;
    logic [KIW-1:0]       kidx;
    logic                 tap_on;
    logic signed [DW-1:0] smp_s, coef_s;
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      for (int kj = 0; kj < MAX_KERNEL; kj++) begin
        sl_sum  = SW'(s2_item.base) + SW'(ki);
        sl_idx  = (int'(sl_sum) >= MAX_KERNEL) ? JW'(sl_sum - SW'(MAX_KERNEL)) : JW'(sl_sum);
        jj      = kc - KW'(1) - KW'(kj);
        col_idx = JW'(jj);
        kidx    = KIW'(ki * int'(kc) + kj);
        tap_on  = (int'(kr) > ki) && (int'(kc) > kj);
        smp_s   = tap_on ? $signed(win[sl_idx][col_idx]) : '0;
        coef_s  = tap_on ? kern_r[kidx] : '0;
        prod_nxt[ki][kj] = smp_s * coef_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid && s2_item.smp && s2_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item_r <= s2_item;
      prod_r    <= prod_nxt;
    end
  end

  // row sums
  always_comb begin
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      rsum_nxt[ki] = '0;
      for (int kj = 0; kj < MAX_KERNEL; kj++) begin
        rsum_nxt[ki] = rsum_nxt[ki] + RW'(prod_r[ki][kj]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_item_r <= s3_item_r;
      rsum_r    <= rsum_nxt;
    end
  end

  // window total, floor shift to q8.8 and saturation
  always_comb begin
    total = '0;
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      total = total + ACW'(rsum_r[ki]);
    end
    shifted = total >>> c2dv_pkg::FRAC_SHIFT;
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[DW-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[DW-1:0];
    end else begin
      sat_value = shifted[DW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid_r) begin
      out_value_r <= sat_value;
      out_row_r   <= s4_item_r.row;
      out_col_r   <= s4_item_r.col;
      out_last_r  <= s4_item_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_valid_r) |=> out_valid_r)
    else $error("window sum lost before output register");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int KMAX          = c2dv_pkg::MAX_KERNEL_DEF;
  localparam int CMAX          = c2dv_pkg::MAX_MAP_COLS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 14;
  localparam int PHASE_ITEMS   = 110;
  localparam int NUM_DIRECTED  = 18;

  // one window result as it leaves the block
  typedef struct packed {
    logic signed [c2dv_pkg::DATA_W-1:0] value;
    logic [c2dv_pkg::ROW_W-1:0]         row;
    logic [c2dv_pkg::COL_W-1:0]         col;
    logic                               last;
  } conv_result_t;

  // one input item, with a hand-written result where it is obvious
  typedef struct packed {
    logic                               cmd;
    logic signed [c2dv_pkg::DATA_W-1:0] value;
    logic [c2dv_pkg::CIDX_W-1:0]        idx;
    logic                               typed;
    conv_result_t                       exp;
  } stim_row_t;

  localparam conv_result_t NO_RES = '{16'sh0000, 10'd0, 6'd0, 1'b0};

  // directed rows: map 2 x 3, kernel 1 x 1
  localparam stim_row_t DIR_TAB [NUM_DIRECTED] = '{
    '{c2dv_pkg::CMD_COEF,   16'sh1000, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh7FFF, 5'd0,  1'b1, '{16'sh7FFF, 10'd0, 6'd0, 1'b0}},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh8000, 5'd0,  1'b1, '{16'sh8000, 10'd0, 6'd1, 1'b0}},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh0000, 5'd0,  1'b1, '{16'sh0000, 10'd0, 6'd2, 1'b0}},
    '{c2dv_pkg::CMD_COEF,   16'sh7FFF, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh7FFF, 5'd0,  1'b1, '{16'sh7FFF, 10'd1, 6'd0, 1'b0}},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh8000, 5'd0,  1'b1, '{16'sh8000, 10'd1, 6'd1, 1'b0}},
    // index past the kernel store is dropped
    '{c2dv_pkg::CMD_COEF,   16'sh0001, 5'd31, 1'b0, NO_RES},
    // floor rounding of a small negative sum, end of frame
    '{c2dv_pkg::CMD_SAMPLE, 16'shFFFF, 5'd0,  1'b1, '{16'shFFF8, 10'd1, 6'd2, 1'b1}},
    '{c2dv_pkg::CMD_COEF,   16'sh8000, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh8000, 5'd0,  1'b1, '{16'sh7FFF, 10'd0, 6'd0, 1'b0}},
    '{c2dv_pkg::CMD_COEF,   16'sh0001, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'shFFFF, 5'd0,  1'b1, '{16'shFFFF, 10'd0, 6'd1, 1'b0}},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh0001, 5'd31, 1'b1, '{16'sh0000, 10'd0, 6'd2, 1'b0}},
    '{c2dv_pkg::CMD_COEF,   16'sh0800, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh1234, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh4321, 5'd0,  1'b0, NO_RES},
    '{c2dv_pkg::CMD_SAMPLE, 16'sh00FF, 5'd0,  1'b0, NO_RES}
  };

  // fixed settings for the first phases: rows, cols, kernel rows, kernel cols
  localparam int FIX_ROWS  [6] = '{2047, 3,   1, 0, 6, 1024};
  localparam int FIX_COLS  [6] = '{1,    127, 64, 5, 6, 64};
  localparam int FIX_KROWS [6] = '{1,    3,   7, 1, 5, 5};
  localparam int FIX_KCOLS [6] = '{1,    5,   0, 5, 5, 5};

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [c2dv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [c2dv_pkg::DIM_W-1:0]     cfg_wdata;

  c2dv_in_if  in_bus ();
  c2dv_out_if out_bus ();

  conv2d_valid_sliding_window uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [c2dv_pkg::DIM_W-1:0]         rows_reg;
  logic [c2dv_pkg::MC_REG_W-1:0]      cols_reg;
  logic [c2dv_pkg::K_REG_W-1:0]       krows_reg;
  logic [c2dv_pkg::K_REG_W-1:0]       kcols_reg;
  logic signed [c2dv_pkg::DATA_W-1:0] coef_mem [KMAX*KMAX];
  logic signed [c2dv_pkg::DATA_W-1:0] line_mem [KMAX][CMAX];
  int unsigned                        row_pos;
  int unsigned                        col_pos;

  stim_row_t    offered_q [$];
  conv_result_t window_q [$];

  int  errors;
  int  items_in;
  int  results_seen;
  int  settings_used;
  bit  quiet_in;
  bit  quiet_out;
  bit  hold_req;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // window sum for one item; returns 1 when the item completes a window
  function automatic bit conv_step(input logic cmd,
                                   input logic signed [c2dv_pkg::DATA_W-1:0] v,
                                   input logic [c2dv_pkg::CIDX_W-1:0] ix,
                                   output conv_result_t res);
    int unsigned kr, kc, mr, mc, r, c, r0, c0;
    bit frame_end, emit;
    longint acc, q;
    res = NO_RES;
    kr = clamp_dim(krows_reg, 1, KMAX);
    kc = clamp_dim(kcols_reg, 1, KMAX);
    mr = clamp_dim(rows_reg, 1, c2dv_pkg::MAX_MAP_ROWS);
    mc = clamp_dim(cols_reg, 1, CMAX);
    if (cmd == c2dv_pkg::CMD_COEF) begin
      if (ix < KMAX*KMAX) coef_mem[ix] = v;
      return 1'b0;
    end
    r = row_pos;
    c = col_pos;
    if (c < CMAX) line_mem[r % KMAX][c] = v;
    // advance raster position, wrapping past a shrunk size too
    frame_end = 1'b0;
    if (c + 1 >= mc) begin
      col_pos = 0;
      if (r + 1 >= mr) begin
        row_pos = 0;
        frame_end = 1'b1;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
    emit = (r < mr) && (c < mc) && (r + 1 >= kr) && (c + 1 >= kc);
    if (!emit) return 1'b0;
    r0 = r + 1 - kr;
    c0 = c + 1 - kc;
    acc = 0;
    for (int ki = 0; ki < kr; ki++) begin
      for (int kj = 0; kj < kc; kj++) begin
        acc += longint'(line_mem[(r0 + ki) % KMAX][c0 + kj]) *
               longint'(coef_mem[ki*kc + kj]);
      end
    end
    // floor shift to q8.8, then saturate
    q = acc >>> c2dv_pkg::FRAC_SHIFT;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.value = q[c2dv_pkg::DATA_W-1:0];
    res.row   = r0[c2dv_pkg::ROW_W-1:0];
    res.col   = c0[c2dv_pkg::COL_W-1:0];
    res.last  = frame_end;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [c2dv_pkg::DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic stim_row_t rand_item();
    stim_row_t it;
    int p;
    it = '0;
    it.cmd = ($urandom_range(0, 99) < 12) ? c2dv_pkg::CMD_COEF : c2dv_pkg::CMD_SAMPLE;
    it.idx = c2dv_pkg::CIDX_W'($urandom_range(0, 31));
    p = $urandom_range(0, 99);
    if (it.cmd == c2dv_pkg::CMD_SAMPLE) begin
      it.value = (p < 10) ? extreme_value() : c2dv_pkg::DATA_W'($urandom);
    end else if (p < 50) begin
      it.value = c2dv_pkg::DATA_W'(int'($urandom_range(0, 4095)) - 2048);
    end else if (p < 80) begin
      it.value = c2dv_pkg::DATA_W'($urandom);
    end else begin
      it.value = extreme_value();
    end
    return it;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor reset values
  initial begin
    rows_reg  = c2dv_pkg::MAP_ROWS_RST;
    cols_reg  = c2dv_pkg::MAP_COLS_RST;
    krows_reg = c2dv_pkg::KERNEL_ROWS_RST;
    kcols_reg = c2dv_pkg::KERNEL_COLS_RST;
    row_pos   = 0;
    col_pos   = 0;
    for (int i = 0; i < KMAX*KMAX; i++) coef_mem[i] = '0;
    for (int i = 0; i < KMAX; i++)
      for (int j = 0; j < CMAX; j++) line_mem[i][j] = '0;
  end

  // transfer monitor and result check
  always @(posedge clk) begin : scoreboard
    stim_row_t    it;
    conv_result_t res;
    conv_result_t got;
    conv_result_t want;
    bit           hit;
    if (cfg_we) begin
      case (c2dv_pkg::cfg_reg_t'(cfg_index))
        c2dv_pkg::CFG_MAP_ROWS:    rows_reg  = cfg_wdata;
        c2dv_pkg::CFG_MAP_COLS:    cols_reg  = cfg_wdata[c2dv_pkg::MC_REG_W-1:0];
        c2dv_pkg::CFG_KERNEL_ROWS: krows_reg = cfg_wdata[c2dv_pkg::K_REG_W-1:0];
        c2dv_pkg::CFG_KERNEL_COLS: kcols_reg = cfg_wdata[c2dv_pkg::K_REG_W-1:0];
        default: ;
      endcase
    end
    if (in_bus.valid && in_bus.ready) begin
      it = offered_q.pop_front();
      hit = conv_step(in_bus.cmd, in_bus.value, in_bus.coef_index, res);
      if (it.typed) window_q.push_back(it.exp);
      else if (hit) window_q.push_back(res);
      items_in++;
    end
    if (out_bus.valid && out_bus.ready) begin
      got = '{out_bus.out_value, out_bus.out_row, out_bus.out_col, out_bus.last};
      results_seen++;
      if (window_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: value %h row %0d col %0d last %b",
                 $time, got.value, got.row, got.col, got.last);
      end else begin
        want = window_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected value %h row %0d col %0d last %b",
                   $time, want.value, want.row, want.col, want.last,
                   ", got value %h row %0d col %0d last %b",
                   got.value, got.row, got.col, got.last);
        end
      end
    end
  end

  // result side back-pressure
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (quiet_out) begin
        out_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // no-progress watchdog
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, idle, window_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

  // offer one item and hold it until the transfer; returns at a falling edge
  task automatic offer_item(input stim_row_t it, input int gap);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    offered_q.push_back(it);
    in_bus.valid      = 1'b1;
    in_bus.cmd        = it.cmd;
    in_bus.value      = it.value;
    in_bus.coef_index = it.idx;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input c2dv_pkg::cfg_reg_t idx, input int data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = c2dv_pkg::DIM_W'(data);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_setting(input int rows, input int cols, input int krows, input int kcols);
    write_reg(c2dv_pkg::CFG_MAP_ROWS, rows);
    write_reg(c2dv_pkg::CFG_MAP_COLS, cols);
    write_reg(c2dv_pkg::CFG_KERNEL_ROWS, krows);
    write_reg(c2dv_pkg::CFG_KERNEL_COLS, kcols);
    settings_used++;
  endtask

  // wait for every expected result, then, when asked, let the pipeline empty
  task automatic drain(input bit with_settle);
    in_bus.valid = 1'b0;
    while (window_q.size() != 0) @(negedge clk);
    if (with_settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int sender_gap();
    if (quiet_in) return 0;
    return ($urandom_range(0, 9) < 6) ? 0 : pick_gap();
  endfunction

  // stimulus
  initial begin : stimulus
    stim_row_t it;
    int p, rows, cols, krows, kcols;
    errors = 0;
    items_in = 0;
    results_seen = 0;
    settings_used = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = c2dv_pkg::CFG_MAP_ROWS;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = c2dv_pkg::CMD_COEF;
    in_bus.value = '0;
    in_bus.coef_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    apply_setting(2, 3, 1, 1);
    for (int i = 0; i < NUM_DIRECTED; i++) offer_item(DIR_TAB[i], sender_gap());

    // fill the whole kernel store before wider kernels are used
    for (int i = 0; i < KMAX*KMAX; i++) begin
      it = rand_item();
      it.cmd = c2dv_pkg::CMD_COEF;
      it.idx = c2dv_pkg::CIDX_W'(i);
      offer_item(it, sender_gap());
    end

    // random phases, each under its own setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain(1'b1);
      if (ph < 6) begin
        rows  = FIX_ROWS[ph];
        cols  = FIX_COLS[ph];
        krows = FIX_KROWS[ph];
        kcols = FIX_KCOLS[ph];
      end else begin
        p = $urandom_range(0, 9);
        rows = (p < 7) ? $urandom_range(1, 12) :
               (p == 7) ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1024, 2047)) :
               $urandom_range(13, 300);
        p = $urandom_range(0, 9);
        cols = (p < 7) ? $urandom_range(1, 16) :
               (p == 7) ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127)) :
               $urandom_range(17, 64);
        krows = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 8) % 8;
        kcols = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 8) % 8;
      end
      apply_setting(rows, cols, krows, kcols);
      quiet_in  = (ph == 0) || (ph == 5) || ($urandom_range(0, 3) == 0);
      quiet_out = (ph == 5) || ($urandom_range(0, 4) == 0);
      // long receiver hold-off while the sender keeps pushing, one result per sample
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender pause until the block has delivered everything
        if (ph == 3 && k == PHASE_ITEMS/2) drain(1'b0);
        offer_item(rand_item(), sender_gap());
      end
    end

    drain(1'b1);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("tb_top: %0d items transferred under %0d register settings",
             items_in, settings_used);
    $display("tb_top: %0d window results compared, %0d mismatches", results_seen, errors);
    if (errors == 0 && window_q.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
